### rtl/sitda_pkg.sv
// Shared types, constants and helper functions for the integer to decimal text block.
`timescale 1ns / 1ps

package sitda_pkg;

    localparam int unsigned VALUE_W        = 64;
    localparam int unsigned NUM_DIGITS     = 20;
    localparam int unsigned BCD_W          = NUM_DIGITS * 4;
    localparam int unsigned BITS_PER_CYCLE = 4;
    localparam int unsigned CONV_ITERS     = VALUE_W / BITS_PER_CYCLE;
    localparam int unsigned ITER_W         = $clog2(CONV_ITERS);
    localparam int unsigned POS_W          = $clog2(NUM_DIGITS);
    localparam int unsigned CHAR_W         = 6;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // Classified number: sign and unsigned magnitude
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_item;

    // Converted number: sign and packed BCD digits, least significant digit at bit 0
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } t_conv_res;

    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_DONE
    } t_conv_state;

    // Several shift-and-add-3 steps, most significant input bit first
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                               input logic [BITS_PER_CYCLE-1:0] bits);
        logic [BCD_W-1:0] acc;
        acc = bcd;
        for (int s = 0; s < BITS_PER_CYCLE; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (acc[d*4 +: 4] >= 4'd5) begin
                    acc[d*4 +: 4] = acc[d*4 +: 4] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], bits[BITS_PER_CYCLE-1-s]};
        end
        return acc;
    endfunction

    // Position of the most significant non-zero digit; 0 when all digits are zero
    function automatic logic [POS_W-1:0] msd_index(input logic [BCD_W-1:0] bcd);
        logic [POS_W-1:0] idx;
        idx = '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd[d*4 +: 4] != 4'd0) begin
                idx = POS_W'(d);
            end
        end
        return idx;
    endfunction

endpackage

### rtl/sitda_front.sv
// Input stage: takes a signed value and registers its sign and magnitude.
`timescale 1ns / 1ps

module sitda_front
    import sitda_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_push_valid,
    input  logic                      i_push_ready,
    output t_item                     o_push_data
);

    logic  r_valid;
    t_item r_item;
    logic  w_take;

    assign o_ready      = !r_valid || i_push_ready;
    assign w_take       = i_valid && o_ready;
    assign o_push_valid = r_valid;
    assign o_push_data  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Magnitude taken as unsigned, so the most negative value gives 2^63
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.neg <= i_value[VALUE_W-1];
            r_item.mag <= i_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(i_value))
                                             : VALUE_W'(i_value);
        end
    end

endmodule

### rtl/sitda_fifo.sv
// Short queue of classified numbers between front and converter.
`timescale 1ns / 1ps

module sitda_fifo
    import sitda_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_data,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_pop_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

### rtl/sitda_conv.sv
// Binary to BCD converter: shift-and-add-3, four magnitude bits per cycle.
`timescale 1ns / 1ps

module sitda_conv
    import sitda_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_item_valid,
    output logic      o_item_ready,
    input  t_item     i_item,
    output logic      o_res_valid,
    input  logic      i_res_ready,
    output t_conv_res o_res
);

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CONV_ITERS - 1);

    t_conv_state        r_state;
    t_conv_state        n_state;
    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [ITER_W-1:0]  r_cnt;
    logic               r_neg;
    logic               w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;
        case (r_state)
            C_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    n_state = C_RUN;
                end
            end
            C_RUN: begin
                if (r_cnt == ITER_LAST) begin
                    n_state = C_DONE;
                end
            end
            C_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    o_item_ready = 1'b1;
                    n_state      = i_item_valid ? C_RUN : C_IDLE;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    assign w_load    = o_item_ready && i_item_valid;
    assign o_res.neg = r_neg;
    assign o_res.bcd = r_bcd;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bin <= i_item.mag;
            r_neg <= i_item.neg;
            r_bcd <= '0;
            r_cnt <= '0;
        end else if (r_state == C_RUN) begin
            r_bcd <= dabble(r_bcd, r_bin[VALUE_W-1 -: BITS_PER_CYCLE]);
            r_bin <= {r_bin[VALUE_W-BITS_PER_CYCLE-1:0], BITS_PER_CYCLE'(0)};
            r_cnt <= r_cnt + 1'b1;
        end
    end

endmodule

### rtl/sitda_emit.sv
// Character emitter: sign, then digits from the most significant non-zero one.
`timescale 1ns / 1ps

module sitda_emit
    import sitda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    output logic              o_res_ready,
    input  t_conv_res         i_res,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_character,
    output logic              o_last
);

    logic              r_busy;
    logic              r_neg;
    logic [BCD_W-1:0]  r_bcd;
    logic [POS_W-1:0]  r_pos;
    logic              r_ovalid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic              w_issue;
    logic              w_final;
    logic [3:0]        w_digit;

    assign w_issue     = r_busy && (!r_ovalid || i_ready);
    assign w_final     = !r_neg && (r_pos == '0);
    assign w_digit     = r_bcd[{r_pos, 2'b00} +: 4];
    assign o_res_ready = !r_busy || (w_issue && w_final);

    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_res_valid && o_res_ready) begin
                r_busy <= 1'b1;
            end else if (w_issue && w_final) begin
                r_busy <= 1'b0;
            end
            if (w_issue) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid && o_res_ready) begin
            r_neg <= i_res.neg;
            r_bcd <= i_res.bcd;
            r_pos <= msd_index(i_res.bcd);
        end else if (w_issue) begin
            if (r_neg) begin
                r_neg <= 1'b0;
            end else if (r_pos != '0) begin
                r_pos <= r_pos - 1'b1;
            end
        end
        if (w_issue) begin
            r_char <= r_neg ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(w_digit));
            r_last <= w_final;
        end
    end

endmodule

### rtl/signed_int_to_decimal_ascii.sv
// Top level: signed 64-bit integer to decimal ASCII text, one character per transaction.
`timescale 1ns / 1ps

// Each input transaction carries one signed 64-bit number; the block returns its
// decimal text as a run of output transactions, one ASCII character each: a minus
// sign for negative values, then the digits most significant first with no
// leading zeros ('0' alone for zero). o_last marks the final character. The most
// negative value prints correctly as -9223372036854775808. Internally a front
// stage splits sign and magnitude, a short queue (QUEUE_DEPTH entries) holds
// waiting numbers, a shift-and-add-3 converter turns four magnitude bits into BCD
// per cycle, and an emitter walks the BCD digits out through a registered
// output. Converter and emitter overlap, so one number is converted while the
// previous one is still being sent; a number's text is 1 to 20 characters long.
// No state is kept between numbers.

module signed_int_to_decimal_ascii
    import sitda_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [CHAR_W-1:0]         o_character,
    output logic                      o_last
);

    // front -> queue
    logic      w_push_valid;
    logic      w_push_ready;
    t_item     w_push_data;
    // queue -> converter
    logic      w_pop_valid;
    logic      w_pop_ready;
    t_item     w_pop_data;
    // converter -> emitter
    logic      w_res_valid;
    logic      w_res_ready;
    t_conv_res w_res;

    sitda_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    sitda_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    // Conversion runs while the emitter is still sending the previous number
    sitda_conv u_conv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_pop_valid),
        .o_item_ready (w_pop_ready),
        .i_item       (w_pop_data),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res)
    );

    sitda_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .o_res_ready (w_res_ready),
        .i_res       (w_res),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

### rtl/sitda_checker.sv
// Port-level checks on the character stream, bound to the top level.
`timescale 1ns / 1ps

module sitda_checker
    import sitda_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic [CHAR_W-1:0] o_character,
    input logic              o_last
);

    logic r_at_start;
    logic r_first_digit;
    logic w_out;

    assign w_out = o_valid && i_ready;

    // Track position within the text of the current number
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start    <= 1'b1;
            r_first_digit <= 1'b1;
        end else if (w_out) begin
            r_at_start    <= o_last;
            r_first_digit <= o_last || (o_character == CHAR_MINUS);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_character) && $stable(o_last))
        else $error("output transaction changed while stalled");

    a_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == CHAR_MINUS) ||
                    ((o_character >= CHAR_ZERO) && (o_character <= CHAR_NINE)))
        else $error("character outside sign and digits");

    a_minus_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_character == CHAR_MINUS) |-> r_at_start && !o_last)
        else $error("minus sign not leading or ends the text");

    a_no_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_first_digit && (o_character == CHAR_ZERO) |-> o_last && r_at_start)
        else $error("leading zero or negative zero");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_character (o_character),
    .o_last      (o_last)
);
